### sv/wbps_pkg.sv
package wbps_pkg;

    // Window depth default and the widest signature the registers can hold.
    localparam int WINDOW_BYTES_DEF = 16;
    localparam int PATTERN_MAX      = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR    = 3'd4;

    // Record kinds carried on tuser.
    localparam logic RECORD_MATCH = 1'b0;
    localparam logic RECORD_END   = 1'b1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    // One result record.
    typedef struct packed {
        logic        kind;
        logic [63:0] address;
        logic [31:0] total;
        logic        run_end;
    } record_t;

    // Records produced by one byte, match first.
    typedef struct packed {
        logic    match_valid;
        record_t match_rec;
        logic    end_valid;
        record_t end_rec;
    } push_t;

endpackage

### sv/wildcard_byte_pattern_scanner.sv
// A byte accepted on the input is held in the input register; its records are written
// into the result queue from there, and the queue head drives the result port.
// Throughput: one byte per cycle while the result queue has room; a byte that gives a match and an end record
// puts both on the single output port, one after the other.
// The eight-entry result queue lets input continue while results wait.
// Reset (aresetn low, synchronous) clears the window, counters and queue and sets
// the registers to zero with pattern_length one.
module wildcard_byte_pattern_scanner #(
    parameter int WINDOW_BYTES = wbps_pkg::WINDOW_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    // Byte stream in.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic                             s_tlast,  // last_byte
    // Records out.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [95:0]                      m_tdata,  // [63:0] match_address, [95:64] match_total
    output logic [0:0]                       m_tuser,  // [0] record_kind
    output logic                             m_tlast   // run_end
);
    import wbps_pkg::*;

    push_t   push;
    record_t head;
    logic    space_ok;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = space_ok;
    assign in_accept = s_tvalid && s_tready;

    // Window, compares and counters.
    wbps_match_core #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push)
    );

    // Result queue in front of the output port.
    wbps_record_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .space_ok   (space_ok)
    );

    assign m_tdata = {head.total, head.address};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_end;

endmodule

### sv/wbps_match_core.sv
module wbps_match_core #(
    parameter int WINDOW_BYTES = wbps_pkg::WINDOW_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                        cfg_data,
    input  logic                               in_accept,
    input  logic [7:0]                         in_byte,
    input  logic                               in_last,
    output wbps_pkg::push_t                    push
);
    import wbps_pkg::*;

    localparam int WIN_IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam logic [4:0] WIN_LEN = 5'(WINDOW_BYTES);

    // Configuration registers.
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_len_reg;
    logic [63:0] base_addr_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Scan state.
    logic [7:0]  win_reg [WINDOW_BYTES];
    logic [7:0]  win_next [WINDOW_BYTES];
    logic [31:0] seen_reg;
    logic [31:0] seen_next;
    logic [31:0] matches_reg;
    logic [31:0] matches_next;

    logic [4:0]   eff_len;
    logic [127:0] pattern;
    logic [4:0]   pos;
    logic         all_equal;
    logic         enough;
    logic         hit;
    logic [31:0]  offset;

    // Register writes; unused indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            pattern_len_reg  <= 5'd1;
            base_addr_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                REG_CARE_MASK:    care_mask_reg    <= cfg_data[15:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_data[4:0];
                REG_BASE_ADDR:    base_addr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // Length zero acts as one; lengths past the window are clipped.
    always_comb begin
        eff_len = pattern_len_reg;
        if (eff_len == 5'd0) begin
            eff_len = 5'd1;
        end
        if (eff_len > WIN_LEN) begin
            eff_len = WIN_LEN;
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    // Shifted window with the new byte at the front.
    always_comb begin
        win_next[0] = in_byte_reg;
        for (int k = 1; k < WINDOW_BYTES; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    // Parallel byte compares; signature byte i lines up with window entry len-1-i.
    always_comb begin
        all_equal = 1'b1;
        pos       = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((5'(i) < eff_len) && care_mask_reg[i]) begin
                pos = eff_len - 5'd1 - 5'(i);
                if (win_next[pos[WIN_IDX_W-1:0]] != pattern[i*8 +: 8]) begin
                    all_equal = 1'b0;
                end
            end
        end
    end

    // Offset, match count and hit decision.
    assign seen_next = seen_reg + 32'd1;
    assign enough    = seen_next >= {27'd0, eff_len};
    assign hit       = enough && all_equal;
    assign offset    = seen_next - {27'd0, eff_len};

    always_comb begin
        matches_next = matches_reg;
        if (hit && (matches_reg != '1)) begin
            matches_next = matches_reg + 32'd1;
        end
    end

    // Update the scan state; the last byte starts a fresh scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '{default: '0};
            seen_reg    <= '0;
            matches_reg <= '0;
        end else if (in_valid_reg) begin
            if (in_last_reg) begin
                win_reg     <= '{default: '0};
                seen_reg    <= '0;
                matches_reg <= '0;
            end else begin
                win_reg     <= win_next;
                seen_reg    <= seen_next;
                matches_reg <= matches_next;
            end
        end
    end

    // Records for the result queue.
    always_comb begin
        push.match_valid       = in_valid_reg && hit;
        push.match_rec.kind    = RECORD_MATCH;
        push.match_rec.address = base_addr_reg + {32'd0, offset};
        push.match_rec.total   = matches_next;
        push.match_rec.run_end = !in_last_reg;
        push.end_valid         = in_valid_reg && in_last_reg;
        push.end_rec.kind      = RECORD_END;
        push.end_rec.address   = '0;
        push.end_rec.total     = matches_next;
        push.end_rec.run_end   = 1'b1;
    end

endmodule

### sv/wbps_record_fifo.sv
module wbps_record_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  wbps_pkg::push_t   push,
    output wbps_pkg::record_t head,
    output logic              head_valid,
    input  logic              head_ready,
    output logic              space_ok
);
    import wbps_pkg::*;

    record_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_PTR_W-1:0] end_ptr;
    logic [1:0]            push_n;
    logic                  pop;

    // Up to two records enter per cycle, the match record first.
    assign push_n  = {1'b0, push.match_valid} + {1'b0, push.end_valid};
    assign end_ptr = push.match_valid ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
    assign pop     = head_valid && head_ready;

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
    assign count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.match_valid) begin
            mem[wr_ptr_reg] <= push.match_rec;
        end
        if (push.end_valid) begin
            mem[end_ptr] <= push.end_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    // Room is kept for the byte in the input register and one more.
    assign head       = mem[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign space_ok   = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 4);

endmodule

### sv/wbps_checker.sv
module wbps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import wbps_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output word changed while stalled");

    // An end record closes the byte and carries address zero.
    a_end_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == RECORD_END) |-> m_tlast && (m_tdata[63:0] == 64'd0))
        else $error("malformed end record");

    // A match record without tlast is followed at once by its end record.
    a_end_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser[0] == RECORD_MATCH) && !m_tlast
        |=> m_tvalid && (m_tuser[0] == RECORD_END))
        else $error("end record missing after match on last byte");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
